@@ design/itrt_pkg.sv @@
// itrt_pkg: shared types, constants and character tables for integer_to_radix_text.
// Used by itrt_front, itrt_fifo, itrt_back and the top level.
// No dependencies.
package itrt_pkg;

  // Default depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Digit buffer: one digit per bit of a 32-bit magnitude in base 2
  localparam int MAX_DIGITS = 32;
  localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);

  // Base range that converts; anything else reports an error
  localparam logic [7:0] BASE_MIN = 8'd2;
  localparam logic [7:0] BASE_MAX = 8'd16;
  localparam logic [7:0] BASE_DEC = 8'd10;

  // Fixed characters
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  // Length of the error text, and index of its final character
  localparam int ERR_LEN = 5;
  localparam logic [DIG_CNT_W-1:0] ERR_LAST_IDX = DIG_CNT_W'(ERR_LEN - 1);

  // Job kind chosen by the front end
  typedef enum logic [1:0] {
    KIND_ERR,
    KIND_ZERO,
    KIND_NUM
  } kind_t;

  // One classified conversion job
  typedef struct packed {
    kind_t       kind;
    logic [31:0] mag;
    logic [4:0]  base;
    logic        neg;
  } job_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_DIGIT,
    S_ERR,
    S_ZERO
  } back_state_t;

  // Digit value to ASCII, 0-9 then A-F
  function automatic logic [7:0] digit_char(logic [3:0] d);
    logic [7:0] ch;
    if (d < 4'd10) ch = 8'h30 + {4'd0, d};
    else           ch = 8'h37 + {4'd0, d};
    return ch;
  endfunction

  // Characters of the error text
  function automatic logic [7:0] err_char(logic [2:0] i);
    logic [7:0] ch;
    unique case (i)
      3'd0:    ch = 8'h45; // E
      3'd1:    ch = 8'h72; // r
      3'd2:    ch = 8'h72; // r
      3'd3:    ch = 8'h6F; // o
      3'd4:    ch = 8'h72; // r
      default: ch = 8'h72;
    endcase
    return ch;
  endfunction

endpackage

@@ design/integer_to_radix_text.sv @@
// integer_to_radix_text: converts a signed 32-bit value to ASCII text in base 2..16.
// Depends on itrt_pkg, itrt_front, itrt_fifo and itrt_back.
//
// Usage:
//   Input channel (in_valid/in_stall): one beat carries in_value and in_base.
//   Output channel (out_valid/out_stall): one beat per character, most significant
//   first; out_last marks the final character, out_error is set on every
//   character of the "Error" text given for a base outside 2..16.
//   Base 10 negative values get a leading '-'; other bases print the magnitude.
//   A beat is accepted when valid is high and stall is low.
// Conversion flow:
//   A beat is classified on entry and queued (QUEUE_DEPTH jobs). The back end
//   loads a job from the queue; for a number it divides the magnitude once per
//   digit (the shared divider produces 8 quotient bits per cycle), then emits
//   the sign and the digits. Zero and bad-base jobs go straight to their text.
//   A job is taken from the queue only once the previous job's last character is emitted.
// Reset: synchronous, active low; clears the queue, the sequencer and the output valid flag.
// Stall: out_stall holds the current character; the back end waits, and the
//   queue keeps accepting beats until full, then raises in_stall.
module integer_to_radix_text #(
  parameter int QUEUE_DEPTH = itrt_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_value,
  input  logic        [7:0]  in_base,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [7:0]  out_character,
  output logic               out_last,
  output logic               out_error
);

  itrt_pkg::job_t       new_job;
  itrt_pkg::job_t       head_job;
  itrt_pkg::fifo_stat_t stat;
  logic                 pop;

  itrt_front u_front (
    .in_value (in_value),
    .in_base  (in_base),
    .job      (new_job)
  );

  itrt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid),
    .push_job (new_job),
    .pop      (pop),
    .head_job (head_job),
    .stat     (stat)
  );

  itrt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_job      (head_job),
    .stat          (stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last),
    .out_error     (out_error)
  );

  assign in_stall = stat.full;

endmodule

@@ design/itrt_front.sv @@
// itrt_front: classifies an input beat (bad base, zero, number) and forms its magnitude.
// Depends on itrt_pkg.
module itrt_front (
  input  logic signed [31:0] in_value,
  input  logic        [7:0]  in_base,
  output itrt_pkg::job_t     job
);

  logic bad_base;
  logic is_zero;

  // Base check comes first, so a bad base wins over a zero value
  assign bad_base = (in_base < itrt_pkg::BASE_MIN) || (in_base > itrt_pkg::BASE_MAX);
  assign is_zero  = (in_value == 32'sd0);

  always_comb begin
    job.base = in_base[4:0];
    job.neg  = in_value[31] && (in_base == itrt_pkg::BASE_DEC);
    // Two's complement magnitude; the most negative value stays exact unsigned
    job.mag  = in_value[31] ? (~in_value + 32'd1) : in_value;
    priority if (bad_base) begin
      job.kind = itrt_pkg::KIND_ERR;
    end else if (is_zero) begin
      job.kind = itrt_pkg::KIND_ZERO;
    end else begin
      job.kind = itrt_pkg::KIND_NUM;
    end
  end

endmodule

@@ design/itrt_fifo.sv @@
// itrt_fifo: small job queue that decouples the front end from the back end.
// Depends on itrt_pkg.
module itrt_fifo #(
  parameter int DEPTH = itrt_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  itrt_pkg::job_t         push_job,
  input  logic                   pop,
  output itrt_pkg::job_t         head_job,
  output itrt_pkg::fifo_stat_t   stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  itrt_pkg::job_t   store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_job   = store_r[rd_ptr_r];

  // Pointer and fill-count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) count_nxt = count_r + CNT_W'(1);
    if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) store_r[wr_ptr_r] <= push_job;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue count missed a push");
`endif

endmodule

@@ design/itrt_back.sv @@
// itrt_back: converts queued jobs, 8 quotient bits per cycle, and emits characters.
// Depends on itrt_pkg.
module itrt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  itrt_pkg::job_t       head_job,
  input  itrt_pkg::fifo_stat_t stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_character,
  output logic                 out_last,
  output logic                 out_error
);

  localparam int IW = itrt_pkg::DIG_IDX_W;
  localparam int CW = itrt_pkg::DIG_CNT_W;

  itrt_pkg::back_state_t state_r, state_nxt;

  logic [31:0]   mag_r, mag_nxt;
  logic [4:0]    base_r, base_nxt;
  logic          neg_r, neg_nxt;
  logic [1:0]    step_r, step_nxt;
  logic [3:0]    rem_r, rem_nxt;
  logic [CW-1:0] ndig_r, ndig_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [3:0]    digits_r [itrt_pkg::MAX_DIGITS];

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_char_r, out_char_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_err_r, out_err_nxt;

  logic          out_free;
  logic          emit;
  logic          dig_wr;
  logic [4:0]    div_rem;
  logic [7:0]    div_q;
  logic [31:0]   quot;
  logic [CW-1:0] rd_idx;

  assign out_free = !out_valid_r || !out_stall;
  assign rd_idx   = cnt_r - CW'(1);

  // Eight restoring-division steps on the top byte of the shifting word;
  // the partial remainder carries over from the previous byte of the same digit
  always_comb begin
    div_rem = (step_r == 2'd0) ? 5'd0 : {1'b0, rem_r};
    div_q   = 8'd0;
    for (int k = 0; k < 8; k++) begin
      div_rem = {div_rem[3:0], mag_r[31-k]};
      if (div_rem >= base_r) begin
        div_rem   = div_rem - base_r;
        div_q[7-k] = 1'b1;
      end
    end
  end
  assign quot = {mag_r[23:0], div_q};

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      itrt_pkg::S_IDLE: begin
        if (!stat.empty) begin
          unique case (head_job.kind)
            itrt_pkg::KIND_ERR:  state_nxt = itrt_pkg::S_ERR;
            itrt_pkg::KIND_ZERO: state_nxt = itrt_pkg::S_ZERO;
            itrt_pkg::KIND_NUM:  state_nxt = itrt_pkg::S_DIV;
            default:             state_nxt = itrt_pkg::S_IDLE;
          endcase
        end
      end
      itrt_pkg::S_DIV: begin
        if (step_r == 2'd3 && quot == '0) begin
          state_nxt = neg_r ? itrt_pkg::S_SIGN : itrt_pkg::S_DIGIT;
        end
      end
      itrt_pkg::S_SIGN: begin
        if (out_free) state_nxt = itrt_pkg::S_DIGIT;
      end
      itrt_pkg::S_DIGIT: begin
        if (out_free && cnt_r == CW'(1)) state_nxt = itrt_pkg::S_IDLE;
      end
      itrt_pkg::S_ERR: begin
        if (out_free && cnt_r == itrt_pkg::ERR_LAST_IDX) state_nxt = itrt_pkg::S_IDLE;
      end
      itrt_pkg::S_ZERO: begin
        if (out_free) state_nxt = itrt_pkg::S_IDLE;
      end
      default: state_nxt = itrt_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    mag_nxt      = mag_r;
    base_nxt     = base_r;
    neg_nxt      = neg_r;
    step_nxt     = step_r;
    rem_nxt      = rem_r;
    ndig_nxt     = ndig_r;
    cnt_nxt      = cnt_r;
    pop          = 1'b0;
    dig_wr       = 1'b0;
    emit         = 1'b0;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    out_err_nxt  = out_err_r;
    unique case (state_r)
      itrt_pkg::S_IDLE: begin
        if (!stat.empty) begin
          pop      = 1'b1;
          mag_nxt  = head_job.mag;
          base_nxt = head_job.base;
          neg_nxt  = head_job.neg;
          step_nxt = 2'd0;
          ndig_nxt = '0;
          cnt_nxt  = '0;
        end
      end
      itrt_pkg::S_DIV: begin
        mag_nxt  = quot;
        rem_nxt  = div_rem[3:0];
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          // full word done: remainder is the next digit, least significant first
          dig_wr   = 1'b1;
          ndig_nxt = ndig_r + CW'(1);
          cnt_nxt  = ndig_r + CW'(1);
        end
      end
      itrt_pkg::S_SIGN: begin
        if (out_free) begin
          emit         = 1'b1;
          out_char_nxt = itrt_pkg::CHAR_MINUS;
          out_last_nxt = 1'b0;
          out_err_nxt  = 1'b0;
        end
      end
      itrt_pkg::S_DIGIT: begin
        if (out_free) begin
          emit         = 1'b1;
          out_char_nxt = itrt_pkg::digit_char(digits_r[rd_idx[IW-1:0]]);
          out_last_nxt = (cnt_r == CW'(1));
          out_err_nxt  = 1'b0;
          cnt_nxt      = cnt_r - CW'(1);
        end
      end
      itrt_pkg::S_ERR: begin
        if (out_free) begin
          emit         = 1'b1;
          out_char_nxt = itrt_pkg::err_char(cnt_r[2:0]);
          out_last_nxt = (cnt_r == itrt_pkg::ERR_LAST_IDX);
          out_err_nxt  = 1'b1;
          cnt_nxt      = cnt_r + CW'(1);
        end
      end
      itrt_pkg::S_ZERO: begin
        if (out_free) begin
          emit         = 1'b1;
          out_char_nxt = itrt_pkg::CHAR_ZERO;
          out_last_nxt = 1'b1;
          out_err_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Output beat register: holds while stalled
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit)           out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itrt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= 2'd0;
      ndig_r      <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      ndig_r      <= ndig_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    base_r     <= base_nxt;
    neg_r      <= neg_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
    if (dig_wr) digits_r[ndig_r[IW-1:0]] <= div_rem[3:0];
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign out_error     = out_err_r;

`ifndef SYNTHESIS
  a_digit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itrt_pkg::S_DIGIT) |-> (cnt_r != '0))
    else $error("digit emission with empty count");
  a_ndig_max: assert property (@(posedge clk) disable iff (!rst_n)
    ndig_r <= CW'(itrt_pkg::MAX_DIGITS))
    else $error("digit buffer overflow");
  a_err_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itrt_pkg::S_ERR) |-> (cnt_r <= itrt_pkg::ERR_LAST_IDX))
    else $error("error text index out of range");
  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r != itrt_pkg::S_IDLE))
    else $error("job taken but sequencer stayed idle");
`endif

endmodule
